FILE: src/jec_pkg.sv
// ----------------------------------------------------------------------------
// jec_pkg
// Types and constants shared by the joystick event coalescer modules.
// ----------------------------------------------------------------------------
package jec_pkg;

  localparam int OPCODE_W = 2;
  localparam int NUMBER_W = 8;
  localparam int VALUE_W = 16;
  localparam int KIND_W = 2;
  localparam int INDEX_W = 6;
  localparam int THRESH_W = 15;
  localparam int GAIN_W = 18;
  localparam int TICKS_W = 16;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [OPCODE_W-1:0] OP_BUTTON = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_AXIS = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;

  localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AXIS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_GAIN = 2'd1;
  localparam logic [1:0] REG_COALESCE = 2'd2;
  localparam logic [1:0] REG_AUTOREPEAT = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 18'h30000;
  localparam logic [TICKS_W-1:0] COALESCE_RESET = 16'd1;

  typedef struct packed {
    logic [THRESH_W-1:0] deadzone_threshold;
    logic [GAIN_W-1:0]   axis_gain;
    logic [TICKS_W-1:0]  coalesce_ticks;
    logic [TICKS_W-1:0]  autorepeat_ticks;
  } cfg_t;

endpackage

FILE: src/jec_regs.sv
// ----------------------------------------------------------------------------
// jec_regs
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module jec_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jec_pkg::PADDR_W-1:0]   paddr,
  input  logic [jec_pkg::PDATA_W-1:0]   pwdata,
  output logic [jec_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output jec_pkg::cfg_t                 cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadzone_threshold <= '0;
      cfg.axis_gain <= jec_pkg::GAIN_RESET;
      cfg.coalesce_ticks <= jec_pkg::COALESCE_RESET;
      cfg.autorepeat_ticks <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        jec_pkg::REG_THRESHOLD: begin
          cfg.deadzone_threshold <= pwdata[jec_pkg::THRESH_W-1:0];
        end
        jec_pkg::REG_GAIN: begin
          cfg.axis_gain <= pwdata[jec_pkg::GAIN_W-1:0];
        end
        jec_pkg::REG_COALESCE: begin
          cfg.coalesce_ticks <= pwdata[jec_pkg::TICKS_W-1:0];
        end
        jec_pkg::REG_AUTOREPEAT: begin
          cfg.autorepeat_ticks <= pwdata[jec_pkg::TICKS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      jec_pkg::REG_THRESHOLD: begin
        prdata = jec_pkg::PDATA_W'(cfg.deadzone_threshold);
      end
      jec_pkg::REG_GAIN: begin
        prdata = jec_pkg::PDATA_W'(cfg.axis_gain);
      end
      jec_pkg::REG_COALESCE: begin
        prdata = jec_pkg::PDATA_W'(cfg.coalesce_ticks);
      end
      jec_pkg::REG_AUTOREPEAT: begin
        prdata = jec_pkg::PDATA_W'(cfg.autorepeat_ticks);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

FILE: src/jec_front.sv
// ----------------------------------------------------------------------------
// jec_front
// Accepts events and ticks, applies the dead zone and gain to axis values,
// keeps the snapshot and the publish timer, and queues snapshots to publish.
// ----------------------------------------------------------------------------
module jec_front #(
  parameter int NUM_AXES = 8,
  parameter int NUM_BUTTONS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  jec_pkg::cfg_t                        cfg,
  input  logic                                 event_valid,
  output logic                                 event_stall,
  input  logic [jec_pkg::OPCODE_W-1:0]         opcode,
  input  logic                                 init_flag,
  input  logic [jec_pkg::NUMBER_W-1:0]         event_number,
  input  logic signed [jec_pkg::VALUE_W-1:0]   event_value,
  output logic                                 push_valid,
  input  logic                                 push_full,
  output logic [NUM_BUTTONS + NUM_AXES*jec_pkg::VALUE_W
                + $clog2(NUM_BUTTONS+1) + $clog2(NUM_AXES+1) - 1:0] push_data
);

  localparam int BC_W = $clog2(NUM_BUTTONS + 1);
  localparam int AC_W = $clog2(NUM_AXES + 1);
  localparam int BI_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int AI_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int VW = jec_pkg::VALUE_W;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_EXEC} fstate_t;

  fstate_t state;
  logic [jec_pkg::OPCODE_W-1:0] op_r;
  logic init_r;
  logic [jec_pkg::NUMBER_W-1:0] num_r;
  logic nz_r;
  logic signed [VW:0] dz;
  logic signed [VW+jec_pkg::GAIN_W:0] prod;

  logic [NUM_BUTTONS-1:0] buttons;
  logic [NUM_AXES-1:0][VW-1:0] axes;
  logic [BC_W-1:0] bcnt;
  logic [AC_W-1:0] acnt;
  logic [jec_pkg::TICKS_W-1:0] countdown;
  logic armed;
  logic pending;

  logic [NUM_BUTTONS-1:0] buttons_next;
  logic [NUM_AXES-1:0][VW-1:0] axes_next;
  logic [BC_W-1:0] bcnt_next;
  logic [AC_W-1:0] acnt_next;
  logic [jec_pkg::TICKS_W-1:0] countdown_next;
  logic armed_next;
  logic pending_next;
  logic pub_now;
  logic soon;
  logic btn_hit;
  logic axis_hit;
  logic commit;

  logic signed [VW:0] vx;
  logic signed [VW:0] tx;
  logic signed [VW:0] dz_comb;
  logic signed [jec_pkg::GAIN_W-1:0] gain_s;
  logic signed [VW+jec_pkg::GAIN_W+1:0] rsum;
  logic signed [VW+3:0] rq;
  logic [VW-1:0] shaped;

  assign vx = (VW+1)'(event_value);
  assign tx = {2'b00, cfg.deadzone_threshold};
  assign gain_s = $signed(cfg.axis_gain);

  always_comb begin
    if (vx > tx) begin
      dz_comb = vx - tx;
    end else if (vx < -tx) begin
      dz_comb = vx + tx;
    end else begin
      dz_comb = '0;
    end
  end

  assign rsum = (VW+jec_pkg::GAIN_W+2)'(prod) + (VW+jec_pkg::GAIN_W+2)'(32768);
  assign rq = rsum[VW+jec_pkg::GAIN_W+1:16];

  always_comb begin
    if (rq[VW+3:VW-1] == '0 || rq[VW+3:VW-1] == '1) begin
      shaped = rq[VW-1:0];
    end else if (rq[VW+3]) begin
      shaped = 16'h8000;
    end else begin
      shaped = 16'h7fff;
    end
  end

  assign btn_hit = num_r < jec_pkg::NUMBER_W'(NUM_BUTTONS);
  assign axis_hit = num_r < jec_pkg::NUMBER_W'(NUM_AXES);

  always_comb begin
    buttons_next = buttons;
    axes_next = axes;
    bcnt_next = bcnt;
    acnt_next = acnt;
    countdown_next = countdown;
    armed_next = armed;
    pending_next = pending;
    pub_now = 1'b0;
    soon = 1'b0;
    unique case (op_r)
      jec_pkg::OP_BUTTON: begin
        if (btn_hit) begin
          buttons_next[BI_W'(num_r)] = nz_r;
          if (BC_W'(num_r) >= bcnt) begin
            bcnt_next = BC_W'(num_r) + BC_W'(1);
          end
          soon = init_r;
          pub_now = !init_r;
        end
      end
      jec_pkg::OP_AXIS: begin
        if (axis_hit) begin
          if (AC_W'(num_r) >= acnt) begin
            acnt_next = AC_W'(num_r) + AC_W'(1);
          end
          if (!init_r) begin
            axes_next[AI_W'(num_r)] = shaped;
          end
          soon = 1'b1;
        end
      end
      jec_pkg::OP_TICK: begin
        if (armed) begin
          if (countdown[jec_pkg::TICKS_W-1:1] == '0) begin
            countdown_next = '0;
            pub_now = 1'b1;
          end else begin
            countdown_next = countdown - jec_pkg::TICKS_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    if (pub_now) begin
      armed_next = 1'b0;
      pending_next = 1'b0;
      soon = 1'b0;
    end
    if (!pending_next && soon) begin
      countdown_next = cfg.coalesce_ticks;
      pending_next = 1'b1;
      armed_next = 1'b1;
    end
    if (!armed_next && cfg.autorepeat_ticks != '0) begin
      countdown_next = cfg.autorepeat_ticks;
      armed_next = 1'b1;
    end
  end

  assign commit = (state == F_EXEC) && !(pub_now && push_full);
  assign push_valid = (state == F_EXEC) && pub_now && !push_full;
  assign push_data = {buttons_next, axes_next, bcnt_next, acnt_next};
  assign event_stall = (state != F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      buttons <= '0;
      axes <= '0;
      bcnt <= '0;
      acnt <= '0;
      countdown <= '0;
      armed <= 1'b0;
      pending <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (event_valid) begin
            op_r <= opcode;
            init_r <= init_flag;
            num_r <= event_number;
            nz_r <= (event_value != '0);
            dz <= dz_comb;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          prod <= dz * gain_s;
          state <= F_EXEC;
        end
        F_EXEC: begin
          if (commit) begin
            buttons <= buttons_next;
            axes <= axes_next;
            bcnt <= bcnt_next;
            acnt <= acnt_next;
            countdown <= countdown_next;
            armed <= armed_next;
            pending <= pending_next;
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/jec_queue.sv
// ----------------------------------------------------------------------------
// jec_queue
// Two-entry queue of snapshots between the front and the back.
// ----------------------------------------------------------------------------
module jec_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_full,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic do_push;
  logic do_pop;

  assign push_full = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data = entries[rd_ptr];
  assign do_push = push_valid && !push_full;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: src/jec_back.sv
// ----------------------------------------------------------------------------
// jec_back
// Takes a queued snapshot and sends it out one element per item:
// buttons first, then axes, or a single marker when the snapshot is empty.
// ----------------------------------------------------------------------------
module jec_back #(
  parameter int NUM_AXES = 8,
  parameter int NUM_BUTTONS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  logic [NUM_BUTTONS + NUM_AXES*jec_pkg::VALUE_W
                + $clog2(NUM_BUTTONS+1) + $clog2(NUM_AXES+1) - 1:0] pop_data,
  output logic                                element_valid,
  input  logic                                element_stall,
  output logic [jec_pkg::KIND_W-1:0]          element_kind,
  output logic [jec_pkg::INDEX_W-1:0]         element_index,
  output logic signed [jec_pkg::VALUE_W-1:0]  element_value,
  output logic                                last_of_snapshot
);

  localparam int BC_W = $clog2(NUM_BUTTONS + 1);
  localparam int AC_W = $clog2(NUM_AXES + 1);
  localparam int BI_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int AI_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int VW = jec_pkg::VALUE_W;

  typedef enum logic [1:0] {B_IDLE, B_BTN, B_AXIS, B_MARK} bstate_t;

  bstate_t phase;
  logic [NUM_BUTTONS-1:0] sb;
  logic [NUM_AXES-1:0][VW-1:0] sa;
  logic [BC_W-1:0] sbc;
  logic [AC_W-1:0] sac;
  logic [BI_W-1:0] bidx;
  logic [AI_W-1:0] aidx;

  logic [NUM_BUTTONS-1:0] u_btn;
  logic [NUM_AXES-1:0][VW-1:0] u_axes;
  logic [BC_W-1:0] u_bc;
  logic [AC_W-1:0] u_ac;
  logic load_ok;
  logic btn_last;
  logic axis_last;

  assign {u_btn, u_axes, u_bc, u_ac} = pop_data;
  assign load_ok = !element_valid || !element_stall;
  assign pop_ready = (phase == B_IDLE);
  assign btn_last = (BC_W'(bidx) + BC_W'(1) == sbc);
  assign axis_last = (AC_W'(aidx) + AC_W'(1) == sac);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= B_IDLE;
      element_valid <= 1'b0;
    end else begin
      unique case (phase)
        B_IDLE: begin
          if (load_ok) begin
            element_valid <= 1'b0;
          end
          if (pop_valid) begin
            sb <= u_btn;
            sa <= u_axes;
            sbc <= u_bc;
            sac <= u_ac;
            bidx <= '0;
            aidx <= '0;
            if (u_bc != '0) begin
              phase <= B_BTN;
            end else if (u_ac != '0) begin
              phase <= B_AXIS;
            end else begin
              phase <= B_MARK;
            end
          end
        end
        B_BTN: begin
          if (load_ok) begin
            element_valid <= 1'b1;
            element_kind <= jec_pkg::KIND_BUTTON;
            element_index <= jec_pkg::INDEX_W'(bidx);
            element_value <= {{(VW-1){1'b0}}, sb[bidx]};
            last_of_snapshot <= btn_last && (sac == '0);
            if (btn_last) begin
              phase <= (sac != '0) ? B_AXIS : B_IDLE;
            end else begin
              bidx <= bidx + BI_W'(1);
            end
          end
        end
        B_AXIS: begin
          if (load_ok) begin
            element_valid <= 1'b1;
            element_kind <= jec_pkg::KIND_AXIS;
            element_index <= jec_pkg::INDEX_W'(aidx);
            element_value <= sa[aidx];
            last_of_snapshot <= axis_last;
            if (axis_last) begin
              phase <= B_IDLE;
            end else begin
              aidx <= aidx + AI_W'(1);
            end
          end
        end
        B_MARK: begin
          if (load_ok) begin
            element_valid <= 1'b1;
            element_kind <= jec_pkg::KIND_EMPTY;
            element_index <= '0;
            element_value <= '0;
            last_of_snapshot <= 1'b1;
            phase <= B_IDLE;
          end
        end
        default: begin
          phase <= B_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/joystick_event_coalescer_core.sv
// ----------------------------------------------------------------------------
// joystick_event_coalescer_core
// Joystick snapshot keeper with dead zone, gain, coalescing and autorepeat.
//
//   Channel   Direction  Handshake                    Payload
//   event     in         event_valid / event_stall    opcode, init_flag,
//                                                     event_number, event_value
//   element   out        element_valid / element_stall element_kind,
//                                                     element_index,
//                                                     element_value,
//                                                     last_of_snapshot
//   config    in         APB psel / penable / pready  paddr, pwdata, prdata
//
// Each event or tick passes through the front as accept, gain multiply,
// then state update, held only while the snapshot queue is full. A
// published snapshot leaves the back at one element per cycle unless
// stalled, buttons_in_use + axes_in_use elements (one if empty).
// Reset is synchronous and clears the snapshot, timer and queue.
// ----------------------------------------------------------------------------
module joystick_event_coalescer_core #(
  parameter int NUM_AXES = 8,
  parameter int NUM_BUTTONS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [jec_pkg::PADDR_W-1:0]         paddr,
  input  logic [jec_pkg::PDATA_W-1:0]         pwdata,
  output logic [jec_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                event_valid,
  output logic                                event_stall,
  input  logic [jec_pkg::OPCODE_W-1:0]        opcode,
  input  logic                                init_flag,
  input  logic [jec_pkg::NUMBER_W-1:0]        event_number,
  input  logic signed [jec_pkg::VALUE_W-1:0]  event_value,
  output logic                                element_valid,
  input  logic                                element_stall,
  output logic [jec_pkg::KIND_W-1:0]          element_kind,
  output logic [jec_pkg::INDEX_W-1:0]         element_index,
  output logic signed [jec_pkg::VALUE_W-1:0]  element_value,
  output logic                                last_of_snapshot
);

  localparam int SNAP_W = NUM_BUTTONS + NUM_AXES*jec_pkg::VALUE_W
                          + $clog2(NUM_BUTTONS+1) + $clog2(NUM_AXES+1);

  jec_pkg::cfg_t cfg;
  logic push_valid;
  logic push_full;
  logic [SNAP_W-1:0] push_data;
  logic pop_valid;
  logic pop_ready;
  logic [SNAP_W-1:0] pop_data;

  jec_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jec_front #(
    .NUM_AXES    (NUM_AXES),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .opcode       (opcode),
    .init_flag    (init_flag),
    .event_number (event_number),
    .event_value  (event_value),
    .push_valid   (push_valid),
    .push_full    (push_full),
    .push_data    (push_data)
  );

  jec_queue #(
    .W (SNAP_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  jec_back #(
    .NUM_AXES    (NUM_AXES),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .element_valid    (element_valid),
    .element_stall    (element_stall),
    .element_kind     (element_kind),
    .element_index    (element_index),
    .element_value    (element_value),
    .last_of_snapshot (last_of_snapshot)
  );

endmodule

FILE: src/jec_checker.sv
// ----------------------------------------------------------------------------
// jec_checker
// Port-level checks on the element output of the coalescer core.
// ----------------------------------------------------------------------------
module jec_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                element_valid,
  input logic                                element_stall,
  input logic [jec_pkg::KIND_W-1:0]          element_kind,
  input logic [jec_pkg::INDEX_W-1:0]         element_index,
  input logic signed [jec_pkg::VALUE_W-1:0]  element_value,
  input logic                                last_of_snapshot
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    element_valid && element_stall |=> element_valid && $stable(element_kind)
      && $stable(element_index) && $stable(element_value)
      && $stable(last_of_snapshot))
    else $error("element payload changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    element_valid |-> element_kind == jec_pkg::KIND_BUTTON
      || element_kind == jec_pkg::KIND_AXIS || element_kind == jec_pkg::KIND_EMPTY)
    else $error("element kind out of range");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    element_valid && element_kind == jec_pkg::KIND_EMPTY |->
      last_of_snapshot && element_index == '0 && element_value == '0)
    else $error("empty snapshot marker malformed");

  a_button: assert property (@(posedge clk) disable iff (rst)
    element_valid && element_kind == jec_pkg::KIND_BUTTON |->
      element_value == 16'sd0 || element_value == 16'sd1)
    else $error("button element value is not 0 or 1");

endmodule

bind joystick_event_coalescer_core jec_checker u_jec_checker (
  .clk              (clk),
  .rst              (rst),
  .element_valid    (element_valid),
  .element_stall    (element_stall),
  .element_kind     (element_kind),
  .element_index    (element_index),
  .element_value    (element_value),
  .last_of_snapshot (last_of_snapshot)
);

FILE: verif/joystick_event_coalescer_checker.sv
// ----------------------------------------------------------------------------
// joystick_event_coalescer_checker
// Watches the event, element and register ports of the joystick event
// coalescer. It keeps its own copy of the snapshot, the timer and the
// registers, works out the elements that each accepted item publishes, and
// compares every accepted element with the oldest one still awaited.
// ----------------------------------------------------------------------------
module joystick_event_coalescer_checker
  import jec_pkg::*;
#(
  parameter int NUM_AXES = 8,
  parameter int NUM_BUTTONS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  input  logic                       event_valid,
  input  logic                       event_stall,
  input  logic [OPCODE_W-1:0]        opcode,
  input  logic                       init_flag,
  input  logic [NUMBER_W-1:0]        event_number,
  input  logic signed [VALUE_W-1:0]  event_value,
  input  logic                       element_valid,
  input  logic                       element_stall,
  input  logic [KIND_W-1:0]          element_kind,
  input  logic [INDEX_W-1:0]         element_index,
  input  logic signed [VALUE_W-1:0]  element_value,
  input  logic                       last_of_snapshot,
  output int unsigned                outstanding,
  output int unsigned                mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } element_t;

  element_t                  awaited_elements[$];
  element_t                  oldest;
  cfg_t                      cfg;
  logic                      button_state[NUM_BUTTONS];
  logic signed [VALUE_W-1:0] axis_state[NUM_AXES];
  int unsigned               buttons_used;
  int unsigned               axes_used;
  int unsigned               countdown;
  logic                      timer_armed;
  logic                      publish_pending;

  initial begin
    outstanding = 0;
    mismatches = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Smooth dead zone, then a signed Q2.16 gain with round half up and
  // saturation to Q1.15.
  function automatic logic signed [VALUE_W-1:0] shape_axis_value(
    input logic signed [VALUE_W-1:0] raw
  );
    longint th;
    longint zoned;
    longint scaled;
    th = longint'(cfg.deadzone_threshold);
    if (raw > th) begin
      zoned = raw - th;
    end else if (raw < -th) begin
      zoned = raw + th;
    end else begin
      zoned = 0;
    end
    scaled = (zoned * longint'(signed'(cfg.axis_gain)) + 32768) >>> 16;
    if (scaled > 32767) begin
      scaled = 32767;
    end
    if (scaled < -32768) begin
      scaled = -32768;
    end
    return scaled[VALUE_W-1:0];
  endfunction

  function automatic void push_element(input logic [KIND_W-1:0] kind,
                                       input int unsigned index,
                                       input logic signed [VALUE_W-1:0] value,
                                       input logic last);
    element_t e;
    e.kind = kind;
    e.index = INDEX_W'(index);
    e.value = value;
    e.last = last;
    awaited_elements.push_back(e);
  endfunction

  task automatic step_snapshot(input logic [OPCODE_W-1:0] op,
                               input logic init,
                               input logic [NUMBER_W-1:0] num,
                               input logic signed [VALUE_W-1:0] raw);
    logic        fire_now;
    logic        fire_later;
    int unsigned total;
    int unsigned k;
    fire_now = 1'b0;
    fire_later = 1'b0;
    case (op)
      OP_BUTTON: begin
        if (num < NUM_BUTTONS) begin
          button_state[num] = (raw != 0);
          if (num + 1 > buttons_used) begin
            buttons_used = num + 1;
          end
          if (init) begin
            fire_later = 1'b1;
          end else begin
            fire_now = 1'b1;
          end
        end
      end
      OP_AXIS: begin
        if (num < NUM_AXES) begin
          if (num + 1 > axes_used) begin
            axes_used = num + 1;
          end
          if (!init) begin
            axis_state[num] = shape_axis_value(raw);
          end
          fire_later = 1'b1;
        end
      end
      OP_TICK: begin
        if (timer_armed) begin
          if (countdown <= 1) begin
            countdown = 0;
            fire_now = 1'b1;
          end else begin
            countdown--;
          end
        end
      end
      default: begin
      end
    endcase

    if (fire_now) begin
      total = buttons_used + axes_used;
      if (total == 0) begin
        push_element(KIND_EMPTY, 0, '0, 1'b1);
      end else begin
        k = 0;
        for (int i = 0; i < buttons_used; i++) begin
          k++;
          push_element(KIND_BUTTON, i, VALUE_W'(button_state[i]), k == total);
        end
        for (int i = 0; i < axes_used; i++) begin
          k++;
          push_element(KIND_AXIS, i, axis_state[i], k == total);
        end
      end
      timer_armed = 1'b0;
      publish_pending = 1'b0;
      fire_later = 1'b0;
    end
    if (!publish_pending && fire_later) begin
      countdown = 32'(cfg.coalesce_ticks);
      publish_pending = 1'b1;
      timer_armed = 1'b1;
    end
    if (!timer_armed && cfg.autorepeat_ticks != 0) begin
      countdown = 32'(cfg.autorepeat_ticks);
      timer_armed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      awaited_elements.delete();
      cfg.deadzone_threshold = '0;
      cfg.axis_gain = GAIN_RESET;
      cfg.coalesce_ticks = COALESCE_RESET;
      cfg.autorepeat_ticks = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        button_state[i] = 1'b0;
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_state[i] = '0;
      end
      buttons_used = 0;
      axes_used = 0;
      countdown = 0;
      timer_armed = 1'b0;
      publish_pending = 1'b0;
    end else begin
      if (element_valid && !element_stall) begin
        if (awaited_elements.size() == 0) begin
          report_mismatch($sformatf("unexpected element kind %0d index %0d value %0d last %0d",
                                    element_kind, element_index, element_value,
                                    last_of_snapshot));
        end else begin
          oldest = awaited_elements.pop_front();
          if (element_kind !== oldest.kind) begin
            report_mismatch($sformatf("element_kind %0d, expected %0d",
                                      element_kind, oldest.kind));
          end
          if (element_index !== oldest.index) begin
            report_mismatch($sformatf("element_index %0d, expected %0d",
                                      element_index, oldest.index));
          end
          if (element_value !== oldest.value) begin
            report_mismatch($sformatf("element_value %0d, expected %0d at index %0d",
                                      element_value, oldest.value, oldest.index));
          end
          if (last_of_snapshot !== oldest.last) begin
            report_mismatch($sformatf("last_of_snapshot %0d, expected %0d at index %0d",
                                      last_of_snapshot, oldest.last, oldest.index));
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          {REG_THRESHOLD, 2'b00}: cfg.deadzone_threshold = pwdata[THRESH_W-1:0];
          {REG_GAIN, 2'b00}: cfg.axis_gain = pwdata[GAIN_W-1:0];
          {REG_COALESCE, 2'b00}: cfg.coalesce_ticks = pwdata[TICKS_W-1:0];
          {REG_AUTOREPEAT, 2'b00}: cfg.autorepeat_ticks = pwdata[TICKS_W-1:0];
          default: begin
          end
        endcase
      end
      if (event_valid && !event_stall) begin
        step_snapshot(opcode, init_flag, event_number, event_value);
      end
    end
    outstanding <= awaited_elements.size();
  end

endmodule

FILE: verif/joystick_event_coalescer_core_test.sv
// ----------------------------------------------------------------------------
// joystick_event_coalescer_core_test
// Drives button events, axis events, ticks and register writes into the
// joystick event coalescer: a short directed run through the edge cases,
// then random phases under several register settings, with random gaps
// and output stalls in all but the last. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module joystick_event_coalescer_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import jec_pkg::*;

  localparam int NUM_AXES = 8;
  localparam int NUM_BUTTONS = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 370;
  localparam int PHASES = 5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      event_valid;
  logic                      event_stall;
  logic [OPCODE_W-1:0]       opcode;
  logic                      init_flag;
  logic [NUMBER_W-1:0]       event_number;
  logic signed [VALUE_W-1:0] event_value;
  logic                      element_valid;
  logic                      element_stall = 1'b0;
  logic [KIND_W-1:0]         element_kind;
  logic [INDEX_W-1:0]        element_index;
  logic signed [VALUE_W-1:0] element_value;
  logic                      last_of_snapshot;
  int unsigned               outstanding;
  int unsigned               mismatches;
  int                        cycles = 0;
  bit                        quiet = 1'b0;
  logic [THRESH_W-1:0]       cur_threshold = '0;

  joystick_event_coalescer_core #(
    .NUM_AXES(NUM_AXES),
    .NUM_BUTTONS(NUM_BUTTONS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .opcode(opcode),
    .init_flag(init_flag),
    .event_number(event_number),
    .event_value(event_value),
    .element_valid(element_valid),
    .element_stall(element_stall),
    .element_kind(element_kind),
    .element_index(element_index),
    .element_value(element_value),
    .last_of_snapshot(last_of_snapshot)
  );

  joystick_event_coalescer_checker #(
    .NUM_AXES(NUM_AXES),
    .NUM_BUTTONS(NUM_BUTTONS)
  ) coalescer_check (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .opcode(opcode),
    .init_flag(init_flag),
    .event_number(event_number),
    .event_value(event_value),
    .element_valid(element_valid),
    .element_stall(element_stall),
    .element_kind(element_kind),
    .element_index(element_index),
    .element_value(element_value),
    .last_of_snapshot(last_of_snapshot),
    .outstanding(outstanding),
    .mismatches(mismatches)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    element_stall = !quiet && ($urandom_range(99) < 19);
  end

  task automatic write_register(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(input logic [THRESH_W-1:0] threshold,
                            input logic [GAIN_W-1:0] gain,
                            input logic [TICKS_W-1:0] coalesce,
                            input logic [TICKS_W-1:0] autorepeat);
    write_register(REG_THRESHOLD, PDATA_W'(threshold));
    write_register(REG_GAIN, {{(PDATA_W-GAIN_W){gain[GAIN_W-1]}}, gain});
    write_register(REG_COALESCE, PDATA_W'(coalesce));
    write_register(REG_AUTOREPEAT, PDATA_W'(autorepeat));
    cur_threshold = threshold;
  endtask

  task automatic send_event(input logic [OPCODE_W-1:0] op, input logic init,
                            input logic [NUMBER_W-1:0] num,
                            input logic [VALUE_W-1:0] value);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 19) begin
      event_valid = 1'b0;
      @(negedge clk);
    end
    event_valid = 1'b1;
    opcode = op;
    init_flag = init;
    event_number = num;
    event_value = value;
    @(posedge clk);
    while (event_stall) @(posedge clk);
  endtask

  // The front may still hold an item that publishes nothing when the last
  // awaited element leaves, so the task still waits for it after the drain.
  task automatic wait_idle();
    @(negedge clk);
    event_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_axis_value();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return '0;
      3: return {1'b0, cur_threshold};
      4: return {1'b0, cur_threshold} + 1'b1;
      5: return ~{1'b0, cur_threshold} + 1'b1;
      6: return ~{1'b0, cur_threshold};
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic send_random_item(output bit counted);
    int pick;
    logic [OPCODE_W-1:0] op;
    pick = $urandom_range(99);
    counted = 1'b1;
    if (pick < 35) begin
      send_event(OP_TICK, 1'($urandom_range(1)), NUMBER_W'($urandom_range(255)),
                 VALUE_W'($urandom));
    end else if (pick < 65) begin
      send_event(OP_AXIS, $urandom_range(9) == 0, NUMBER_W'($urandom_range(NUM_AXES-1)),
                 pick_axis_value());
    end else if (pick < 90) begin
      send_event(OP_BUTTON, $urandom_range(4) == 0,
                 NUMBER_W'($urandom_range(NUM_BUTTONS-1)),
                 ($urandom_range(2) == 0) ? '0 : VALUE_W'($urandom));
    end else begin
      if ($urandom_range(2) == 0) begin
        op = OP_UNUSED;
      end else begin
        op = $urandom_range(1) ? OP_AXIS : OP_BUTTON;
      end
      send_event(op, 1'($urandom_range(1)), NUMBER_W'($urandom_range(255, NUM_BUTTONS)),
                 VALUE_W'($urandom));
    end
  endtask

  task automatic configure_phase(input int phase);
    case (phase)
      0: set_config('0, 18'h10000, 16'd0, 16'd0);
      1: set_config(15'h7FFF, 18'h1FFFF, 16'hFFFF, 16'hFFFF);
      2: set_config(THRESH_W'($urandom_range(4000)), 18'h20000,
                    TICKS_W'($urandom_range(4, 1)), TICKS_W'($urandom_range(6, 1)));
      default: set_config(THRESH_W'($urandom_range(1) ? $urandom_range(32767)
                                                      : $urandom_range(2000)),
                          GAIN_W'($urandom), TICKS_W'($urandom_range(6)),
                          TICKS_W'($urandom_range(8)));
    endcase
  endtask

  initial begin
    int counted_items;
    bit counted;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    event_valid = 1'b0;
    opcode = OP_BUTTON;
    init_flag = 1'b0;
    event_number = '0;
    event_value = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: idle tick, unused opcode and out-of-range numbers.
    send_event(OP_TICK, 1'b0, 8'd0, 16'd0);
    send_event(OP_UNUSED, 1'b1, 8'd3, 16'h1234);
    send_event(OP_BUTTON, 1'b0, 8'd255, 16'd1);
    send_event(OP_AXIS, 1'b0, 8'd8, 16'd100);
    wait_idle();

    // Autorepeat with nothing in use publishes the empty snapshot marker.
    write_register(REG_AUTOREPEAT, 32'd2);
    repeat (3) send_event(OP_TICK, 1'b0, 8'd0, 16'd0);
    wait_idle();
    write_register(REG_AUTOREPEAT, 32'd0);
    send_event(OP_AXIS, 1'b0, 8'd1, 16'd12345);
    send_event(OP_TICK, 1'b0, 8'd0, 16'd0);
    send_event(OP_TICK, 1'b0, 8'd0, 16'd0);
    wait_idle();

    // Largest gain saturates both ways; a full snapshot of 24 elements.
    set_config('0, 18'h1FFFF, 16'd0, 16'd0);
    send_event(OP_AXIS, 1'b0, 8'd0, 16'h7FFF);
    send_event(OP_AXIS, 1'b0, 8'd7, 16'h8000);
    send_event(OP_AXIS, 1'b1, 8'd3, 16'd5);
    send_event(OP_BUTTON, 1'b1, 8'd15, 16'h8000);
    send_event(OP_BUTTON, 1'b0, 8'd0, 16'd1);
    send_event(OP_TICK, 1'b0, 8'd0, 16'd0);
    wait_idle();

    // Widest dead zone with the most negative gain.
    set_config(15'h7FFF, 18'h20000, 16'd3, 16'hFFFF);
    send_event(OP_AXIS, 1'b0, 8'd2, 16'h7FFF);
    send_event(OP_AXIS, 1'b0, 8'd4, 16'h8000);
    send_event(OP_BUTTON, 1'b0, 8'd5, 16'd0);
    repeat (4) send_event(OP_TICK, 1'b0, 8'd0, 16'd0);
    wait_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      configure_phase(phase);
      quiet = (phase == PHASES - 1);
      counted_items = 0;
      while (counted_items < ITEM_TARGET / PHASES) begin
        send_random_item(counted);
        counted_items += int'(counted);
      end
      wait_idle();
    end
    quiet = 1'b0;

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
